>>> sv/mhsi_pkg.sv
// Shared types and constants for the magnetometer hard/soft-iron calibration engine.
package mhsi_pkg;

    localparam int MAG_BITS  = 16;
    localparam int OUT_BITS  = 16;
    localparam int GAIN_BITS = 16;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_COLLECT = 2'd1,
        OP_FINISH  = 2'd2,
        OP_CORRECT = 2'd3
    } t_op;

    // per-cycle commands from the sequencer to every axis lane
    typedef struct packed {
        logic clear;
        logic collect;
        logic finish;
        logic div_go;
        logic diff;
        logic mul;
        logic sat;
    } t_lane_ctl;

endpackage

>>> sv/mhsi_div.sv
// Restoring divider, one quotient bit per cycle; caller guarantees the quotient fits.
module mhsi_div #(
    parameter int NUM_BITS = 30,
    parameter int DEN_BITS = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [NUM_BITS-1:0]                 i_num,
    input  logic [DEN_BITS-1:0]                 i_den,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [mhsi_pkg::GAIN_BITS-1:0]      o_quot
);

    localparam int QB = mhsi_pkg::GAIN_BITS;
    localparam int CW = $clog2(QB);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [QB-1:0]       r_low;

    logic [DEN_BITS:0] trial;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_low[QB-1]};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // low word shifts out dividend bits and shifts in quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_BITS'(i_num >> QB);
            r_low <= i_num[QB-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? DEN_BITS'(trial - {1'b0, r_den}) : trial[DEN_BITS-1:0];
            r_low <= {r_low[QB-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

>>> sv/mhsi_lane.sv
// One axis lane: min/max capture, offset, soft-iron scale and sample correction.
module mhsi_lane #(
    parameter int SAMPLE_BITS     = 16,
    parameter int SCALE_FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mhsi_pkg::t_lane_ctl           i_ctl,
    input  logic signed [15:0]            i_sample,
    input  logic signed [SAMPLE_BITS+2:0] i_total,
    output logic signed [SAMPLE_BITS:0]   o_span,
    output logic signed [15:0]            o_offset,
    output logic signed [15:0]            o_corr,
    output logic [15:0]                   o_scale,
    output logic                          o_busy
);

    localparam int SB   = SAMPLE_BITS;
    localparam int F    = SCALE_FRAC_BITS;
    localparam int EW   = (SB > mhsi_pkg::MAG_BITS) ? SB : mhsi_pkg::MAG_BITS;
    localparam int DW   = SB + 2;
    localparam int NW   = SB + 2 + F;
    localparam int PW   = SB + 1 + mhsi_pkg::GAIN_BITS + 1;
    localparam int CMPW = DW + mhsi_pkg::GAIN_BITS;

    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [15:0] UNITY = (F >= 16) ? 16'hFFFF : 16'(1 << F);
    localparam logic signed [PW-1:0] OMAX = PW'(32767);
    localparam logic signed [PW-1:0] OMIN = PW'(-32768);

    logic signed [SB-1:0] r_min;
    logic signed [SB-1:0] r_max;
    logic signed [SB-1:0] r_offset;
    logic [15:0]          r_scale;
    logic signed [SB:0]   r_span;
    logic signed [SB:0]   r_diff;
    logic signed [PW-1:0] r_prod;
    logic signed [15:0]   r_corr;

    logic signed [EW-1:0] s_ext;
    logic signed [SB-1:0] s_clamp;
    logic signed [SB:0]   mid_sum;
    logic signed [SB:0]   mid_new;
    logic signed [SB:0]   span_new;
    logic [SB-1:0]        span_u;
    logic [DW-1:0]        den;
    logic [NW-1:0]        num;
    logic                 span_pos;
    logic                 total_pos;
    logic                 sat_q;
    logic                 div_start;
    logic signed [PW-1:0] prod_sh;
    logic signed [EW-1:0] off_ext;
    logic                 div_busy;
    logic                 div_done;
    logic [15:0]          div_quot;

    always_comb begin
        s_ext = EW'(i_sample);
        if (s_ext > EW'(SMAX)) begin
            s_clamp = SMAX;
        end else if (s_ext < EW'(SMIN)) begin
            s_clamp = SMIN;
        end else begin
            s_clamp = SB'(s_ext);
        end
        mid_sum   = {r_max[SB-1], r_max} + {r_min[SB-1], r_min};
        mid_new   = mid_sum >>> 1;
        span_new  = {r_max[SB-1], r_max} - {r_min[SB-1], r_min};
        span_u    = r_span[SB-1:0];
        den       = {1'b0, span_u, 1'b0} + {2'b00, span_u};
        num       = {i_total[SB+1:0], {F{1'b0}}};
        span_pos  = (r_span > 0);
        total_pos = (i_total > 0);
        // quotient would not fit in 16 bits
        sat_q     = (CMPW'(num) >= {den, {mhsi_pkg::GAIN_BITS{1'b0}}});
        div_start = i_ctl.div_go && span_pos && total_pos && !sat_q;
        prod_sh   = r_prod >>> F;
        off_ext   = EW'(r_offset);
    end

    mhsi_div #(
        .NUM_BITS (NW),
        .DEN_BITS (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= SMAX;
            r_max    <= SMIN;
            r_offset <= '0;
            r_scale  <= UNITY;
        end else begin
            if (i_ctl.clear) begin
                r_min <= SMAX;
                r_max <= SMIN;
            end
            if (i_ctl.collect) begin
                if (s_clamp < r_min) r_min <= s_clamp;
                if (s_clamp > r_max) r_max <= s_clamp;
            end
            if (i_ctl.finish) begin
                r_offset <= mid_new[SB-1:0];
            end
            if (i_ctl.div_go) begin
                if (!span_pos) begin
                    r_scale <= UNITY;
                end else if (!total_pos) begin
                    r_scale <= '0;
                end else if (sat_q) begin
                    r_scale <= 16'hFFFF;
                end
            end
            if (div_done) begin
                r_scale <= div_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_span <= span_new;
        end
        if (i_ctl.diff) begin
            r_diff <= {s_clamp[SB-1], s_clamp} - {r_offset[SB-1], r_offset};
        end
        if (i_ctl.mul) begin
            r_prod <= r_diff * $signed({1'b0, r_scale});
        end
        if (i_ctl.sat) begin
            if (prod_sh > OMAX) begin
                r_corr <= 16'sh7FFF;
            end else if (prod_sh < OMIN) begin
                r_corr <= 16'sh8000;
            end else begin
                r_corr <= 16'(prod_sh);
            end
        end
    end

    assign o_span   = r_span;
    assign o_offset = off_ext[15:0];
    assign o_corr   = r_corr;
    assign o_scale  = r_scale;
    assign o_busy   = div_busy;

endmodule

>>> sv/mag_hard_soft_iron_calibration.sv
// Magnetometer hard/soft-iron min/max calibration engine, three axis lanes and sequencer.
//
// Input stream: one request per beat. s_axis_tuser = {sample_ok, operation};
// s_axis_tdata = {mag_z, mag_y, mag_x}. Operations: start capture, collect a
// sample into the per-axis min/max, finish (offset = floor((max+min)/2),
// scale = sum of spans / (3*span) in Q4.12), correct a sample.
// Output stream: one result per request. m_axis_tdata = {gain_z, gain_y,
// gain_x, out_z, out_y, out_x}; m_axis_tuser = status (1 = ignored).
// Steps from accept to m_axis_tvalid: start, collect and any ignored request go
// from the execute step straight to the result step; correct passes through
// subtract, multiply and saturate; finish sums the spans, then waits for the
// 16-step divider each axis lane owns (no wait when no axis needs a division).
// One request is in work at a time; the next is taken once the previous result
// sits in the output register, and a request may be accepted while that result
// waits for m_axis_tready. A stalled output holds the sequencer in its result
// step until the register frees.
// Reset (i_rst_n low, synchronous) disarms capture, sets min/max to the
// sample extremes, offsets to 0 and scales to 1.0, and empties the output.
module mag_hard_soft_iron_calibration #(
    parameter int SAMPLE_BITS     = 16,
    parameter int SCALE_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // mag_x, mag_y, mag_z
    input  logic [2:0]  s_axis_tuser,   // operation[1:0], sample_ok
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // out_x, out_y, out_z, gain_x, gain_y, gain_z
    output logic        m_axis_tuser    // status
);

    localparam int SB = SAMPLE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TOTAL,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_MUL,
        ST_SAT,
        ST_RESULT
    } t_state;

    t_state               r_state;
    mhsi_pkg::t_op        r_op;
    logic                 r_ok;
    logic                 r_capture;
    logic                 r_status;
    logic signed [15:0]   r_mag [3];
    logic signed [SB+2:0] r_total;
    logic                 r_m_valid;
    logic [95:0]          r_m_data;
    logic                 r_m_user;

    mhsi_pkg::t_lane_ctl  lane_ctl;
    logic signed [SB:0]   lane_span [3];
    logic signed [15:0]   lane_offset [3];
    logic signed [15:0]   lane_corr [3];
    logic [15:0]          lane_scale [3];
    logic [2:0]           lane_busy;
    logic [15:0]          res_val [3];
    logic                 out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        lane_ctl         = '0;
        lane_ctl.clear   = (r_state == ST_EXEC) && (r_op == mhsi_pkg::OP_START);
        lane_ctl.collect = (r_state == ST_EXEC) && (r_op == mhsi_pkg::OP_COLLECT)
                           && r_capture && r_ok;
        lane_ctl.finish  = (r_state == ST_EXEC) && (r_op == mhsi_pkg::OP_FINISH)
                           && r_capture;
        lane_ctl.diff    = (r_state == ST_EXEC) && (r_op == mhsi_pkg::OP_CORRECT) && r_ok;
        lane_ctl.div_go  = (r_state == ST_DIVGO);
        lane_ctl.mul     = (r_state == ST_MUL);
        lane_ctl.sat     = (r_state == ST_SAT);
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        mhsi_lane #(
            .SAMPLE_BITS     (SAMPLE_BITS),
            .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_sample (r_mag[g]),
            .i_total  (r_total),
            .o_span   (lane_span[g]),
            .o_offset (lane_offset[g]),
            .o_corr   (lane_corr[g]),
            .o_scale  (lane_scale[g]),
            .o_busy   (lane_busy[g])
        );

        always_comb begin
            if (r_status) begin
                res_val[g] = '0;
            end else if (r_op == mhsi_pkg::OP_FINISH) begin
                res_val[g] = lane_offset[g];
            end else if (r_op == mhsi_pkg::OP_CORRECT) begin
                res_val[g] = lane_corr[g];
            end else begin
                res_val[g] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_capture <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == ST_RESULT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (r_op)
                        mhsi_pkg::OP_START: begin
                            r_capture <= 1'b1;
                            r_state   <= ST_RESULT;
                        end
                        mhsi_pkg::OP_FINISH: begin
                            if (r_capture) begin
                                r_capture <= 1'b0;
                                r_state   <= ST_TOTAL;
                            end else begin
                                r_state   <= ST_RESULT;
                            end
                        end
                        mhsi_pkg::OP_CORRECT: begin
                            r_state <= r_ok ? ST_MUL : ST_RESULT;
                        end
                        default: r_state <= ST_RESULT;
                    endcase
                end
                ST_TOTAL:   r_state <= ST_DIVGO;
                ST_DIVGO:   r_state <= ST_DIVWAIT;
                ST_DIVWAIT: begin
                    if (lane_busy == '0) r_state <= ST_RESULT;
                end
                ST_MUL:     r_state <= ST_SAT;
                ST_SAT:     r_state <= ST_RESULT;
                ST_RESULT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:    r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_op     <= mhsi_pkg::t_op'(s_axis_tuser[1:0]);
            r_ok     <= s_axis_tuser[2];
            r_mag[0] <= s_axis_tdata[15:0];
            r_mag[1] <= s_axis_tdata[31:16];
            r_mag[2] <= s_axis_tdata[47:32];
        end
        if (r_state == ST_EXEC) begin
            case (r_op)
                mhsi_pkg::OP_COLLECT: r_status <= !r_capture || !r_ok;
                mhsi_pkg::OP_FINISH:  r_status <= !r_capture;
                mhsi_pkg::OP_CORRECT: r_status <= !r_ok;
                default:              r_status <= 1'b0;
            endcase
        end
        if (r_state == ST_TOTAL) begin
            r_total <= (SB+3)'(lane_span[0]) + (SB+3)'(lane_span[1])
                       + (SB+3)'(lane_span[2]);
        end
        if (r_state == ST_RESULT && out_free) begin
            r_m_data <= {lane_scale[2], lane_scale[1], lane_scale[0],
                         res_val[2], res_val[1], res_val[0]};
            r_m_user <= r_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_finish_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_op == mhsi_pkg::OP_FINISH && r_capture) |=> !r_capture)
        else $error("finish did not disarm capture");

    a_div_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_busy != '0) |-> (r_state == ST_DIVWAIT))
        else $error("lane divider busy outside divide wait");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_RESULT))
        else $error("output valid raised outside result step");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[47:0] == '0))
        else $error("ignored request carries nonzero outputs");

endmodule

>>> tb/mag_hard_soft_iron_calibration_test.sv
// Self-checking stream testbench for the magnetometer hard/soft-iron calibration engine.
module mag_hard_soft_iron_calibration_test;

    typedef struct packed {
        logic             status;
        logic [2:0][15:0] gain;
        logic [2:0][15:0] value;
    } t_cal_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // mag_x, mag_y, mag_z
    logic [2:0]  s_axis_tuser;   // operation[1:0], sample_ok
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // out_x, out_y, out_z, gain_x, gain_y, gain_z
    logic        m_axis_tuser;   // status

    mag_hard_soft_iron_calibration dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state, same reset as the block
    bit     capture_armed = 1'b0;
    longint axis_lo[3]    = '{32767, 32767, 32767};
    longint axis_hi[3]    = '{-32768, -32768, -32768};
    longint iron_offset[3] = '{0, 0, 0};
    longint iron_gain[3]  = '{4096, 4096, 4096};

    t_cal_result pending_results[$];
    t_cal_result want;
    int          mismatch_count = 0;
    int          items_sent     = 0;
    bit          tx_gaps_on     = 1'b1;
    bit          rx_stalls_on   = 1'b1;
    bit          long_hold_req  = 1'b0;
    int          rx_gap_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_cal_result calibrate_request(mhsi_pkg::t_op op, bit ok,
                                                      logic [47:0] mag);
        longint      s[3];
        longint      span[3];
        longint      total;
        longint      r;
        t_cal_result res;
        res = '0;
        for (int i = 0; i < 3; i++) s[i] = $signed(mag[16*i +: 16]);
        case (op)
            mhsi_pkg::OP_START: begin
                capture_armed = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    axis_lo[i] = 32767;
                    axis_hi[i] = -32768;
                end
            end
            mhsi_pkg::OP_COLLECT: begin
                if (!capture_armed || !ok) begin
                    res.status = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (s[i] < axis_lo[i]) axis_lo[i] = s[i];
                        if (s[i] > axis_hi[i]) axis_hi[i] = s[i];
                    end
                end
            end
            mhsi_pkg::OP_FINISH: begin
                if (!capture_armed) begin
                    res.status = 1'b1;
                end else begin
                    capture_armed = 1'b0;
                    total = 0;
                    for (int i = 0; i < 3; i++) begin
                        iron_offset[i] = (axis_hi[i] + axis_lo[i]) >>> 1;
                        span[i] = axis_hi[i] - axis_lo[i];
                        total += span[i];
                        res.value[i] = iron_offset[i][15:0];
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (span[i] <= 0) iron_gain[i] = 4096;
                        else if (total <= 0) iron_gain[i] = 0;
                        else begin
                            r = (total << 12) / (span[i] * 3);
                            iron_gain[i] = (r > 65535) ? 65535 : r;
                        end
                    end
                end
            end
            default: begin
                if (!ok) begin
                    res.status = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r = ((s[i] - iron_offset[i]) * iron_gain[i]) >>> 12;
                        if (r > 32767) r = 32767;
                        if (r < -32768) r = -32768;
                        res.value[i] = r[15:0];
                    end
                end
            end
        endcase
        for (int i = 0; i < 3; i++) res.gain[i] = iron_gain[i][15:0];
        return res;
    endfunction

    // one request per call; returns in the time step of the accepting edge
    task automatic send_request(mhsi_pkg::t_op op, bit ok, logic [15:0] x, logic [15:0] y,
                                logic [15:0] z);
        int gap;
        @(negedge i_clk);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = gap_len();
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {ok, op};
        s_axis_tdata  = {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(calibrate_request(op, ok, {z, y, x}));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_axis(int center, int amp, bit wide);
        int v;
        if (wide) return 16'($urandom);
        v = center + int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // receiver: random stalls plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_gap_left = 300;
            end else if (rx_gap_left == 0 && rx_stalls_on && $urandom_range(0, 3) == 0) begin
                rx_gap_left = gap_len();
            end
            if (rx_gap_left > 0) begin
                m_axis_tready = 1'b0;
                rx_gap_left--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic compare_field(string name, logic [15:0] expected, logic [15:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h status %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("out_x", want.value[0], m_axis_tdata[15:0]);
                compare_field("out_y", want.value[1], m_axis_tdata[31:16]);
                compare_field("out_z", want.value[2], m_axis_tdata[47:32]);
                compare_field("gain_x", want.gain[0], m_axis_tdata[63:48]);
                compare_field("gain_y", want.gain[1], m_axis_tdata[79:64]);
                compare_field("gain_z", want.gain[2], m_axis_tdata[95:80]);
                compare_field("status", {15'd0, want.status}, {15'd0, m_axis_tuser});
            end
        end
    end

    // identity calibration after reset, plus requests ignored when not armed or not ok
    task automatic test_uncalibrated();
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'h7fff, 16'h8000, 16'h0000);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'hffff, 16'h0001, 16'h8000);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'h8000, 16'h7fff, 16'hffff);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'h5555, 16'haaaa, 16'h1234);
        send_request(mhsi_pkg::OP_CORRECT, 1'b0, 16'h1234, 16'h5678, 16'h9abc);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, 16'h0100, 16'h0200, 16'h0300);
        send_request(mhsi_pkg::OP_FINISH, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // finish with no samples, one sample (zero span), full-range and equal spans
    task automatic test_edge_sessions();
        send_request(mhsi_pkg::OP_START, 1'b0, 16'hffff, 16'hffff, 16'hffff);
        send_request(mhsi_pkg::OP_FINISH, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_START, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_COLLECT, 1'b0, 16'h7fff, 16'h8000, 16'h7fff);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, 16'd100, -16'sd200, 16'd300);
        send_request(mhsi_pkg::OP_FINISH, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'd90, -16'sd150, 16'd301);
        send_request(mhsi_pkg::OP_START, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, 16'h7fff, 16'd5, -16'sd10);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, 16'h8000, 16'd6, -16'sd8);
        send_request(mhsi_pkg::OP_FINISH, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'h7fff, 16'h8000, 16'h7fff);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'h8000, 16'h7fff, 16'h8000);
        send_request(mhsi_pkg::OP_START, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, 16'd1000, 16'd1000, 16'd1000);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, -16'sd1000, -16'sd1000, -16'sd1000);
        send_request(mhsi_pkg::OP_FINISH, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'd777, -16'sd1, 16'h8000);
    endtask

    // output held off long enough that the block stalls its input
    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        repeat (12) send_request(mhsi_pkg::t_op'($urandom_range(0, 3)), 1'b1, 16'($urandom),
                                 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random_sessions();
        int target;
        int center[3];
        int amp[3];
        bit wide;
        target = items_sent + 1500;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_gaps_on   = $urandom_range(0, 1);
                rx_stalls_on = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_request(mhsi_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 1),
                                 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                wide = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < 3; i++) begin
                    center[i] = int'($urandom_range(0, 6000)) - 3000;
                    amp[i]    = $urandom_range(1, 8000);
                end
                send_request(mhsi_pkg::OP_START, $urandom_range(0, 1), 16'($urandom),
                             16'($urandom), 16'($urandom));
                repeat ($urandom_range(2, 24))
                    send_request(mhsi_pkg::OP_COLLECT, $urandom_range(0, 9) != 0,
                                 pick_axis(center[0], amp[0], wide),
                                 pick_axis(center[1], amp[1], wide),
                                 pick_axis(center[2], amp[2], wide));
                send_request(mhsi_pkg::OP_FINISH, $urandom_range(0, 1), 16'($urandom),
                             16'($urandom), 16'($urandom));
                repeat ($urandom_range(1, 8))
                    send_request(mhsi_pkg::OP_CORRECT, $urandom_range(0, 9) != 0,
                                 pick_axis(center[0], 2 * amp[0], wide),
                                 pick_axis(center[1], 2 * amp[1], wide),
                                 pick_axis(center[2], 2 * amp[2], wide));
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // sender waits for every result, then resumes with a fresh session
    task automatic test_pause_until_drained();
        wait_drained();
        send_request(mhsi_pkg::OP_START, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, 16'd4000, -16'sd300, 16'd20);
        send_request(mhsi_pkg::OP_COLLECT, 1'b1, -16'sd2500, 16'd900, -16'sd60);
        send_request(mhsi_pkg::OP_FINISH, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_request(mhsi_pkg::OP_CORRECT, 1'b1, 16'd1200, 16'd100, 16'h7fff);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_uncalibrated();
        test_edge_sessions();
        test_output_backpressure();
        test_random_sessions();
        test_pause_until_drained();

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
